// ===== rtl/core/aavr_pkg.sv =====
// Shared types and constants of the axis-angle vector rotation pipeline.
package aavr_pkg;

  // Q30 angle and CORDIC widths; these do not follow the coordinate width.
  localparam int ZW = 35;
  localparam int XW = 34;

  localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [XW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  localparam logic [31:0] ATAN_Q30 [24] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
    32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
    32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255,
    32'd127
  };

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 neg;
  } cordic_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] res;
  } sqrt_t;

  typedef struct packed {
    logic [30:0] rem;
    logic [31:0] low;
    logic [31:0] q;
  } div_lane_t;

  typedef struct packed {
    logic [30:0]          len;
    div_lane_t [2:0]      lane;
  } div_t;

endpackage

// ===== rtl/core/aavr_delay.sv =====
// Enabled shift line that carries side data alongside the pipeline stages.
module aavr_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int k = 1; k < DEPTH; k++) begin
        line[k] <= line[k-1];
      end
    end
  end

  assign q = line[DEPTH-1];

endmodule

// ===== rtl/core/aavr_cordic_cell.sv =====
// One rotation-mode CORDIC micro-rotation with its output register.
module aavr_cordic_cell
  import aavr_pkg::*;
#(
  parameter int I = 0
) (
  input  logic    clk,
  input  logic    en,
  input  cordic_t d,
  output cordic_t q
);

  localparam logic signed [ZW-1:0] ATAN = $signed({3'b000, ATAN_Q30[I]});

  cordic_t q_next;

  always_comb begin
    q_next = d;
    if (!d.z[ZW-1]) begin
      q_next.x = d.x - (d.y >>> I);
      q_next.y = d.y + (d.x >>> I);
      q_next.z = d.z - ATAN;
    end else begin
      q_next.x = d.x + (d.y >>> I);
      q_next.y = d.y - (d.x >>> I);
      q_next.z = d.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

// ===== rtl/core/aavr_sqrt_cell.sv =====
// One step of the bitwise integer square root, two radicand bits per cell.
module aavr_sqrt_cell
  import aavr_pkg::*;
#(
  parameter int K = 0
) (
  input  logic  clk,
  input  logic  en,
  input  sqrt_t d,
  output sqrt_t q
);

  localparam logic [63:0] BIT = 64'(1) << (62 - 2 * K);

  sqrt_t       q_next;
  logic [63:0] trial;

  always_comb begin
    trial = d.res + BIT;
    if (d.rem >= trial) begin
      q_next.rem = d.rem - trial;
      q_next.res = (d.res >> 1) + BIT;
    end else begin
      q_next.rem = d.rem;
      q_next.res = d.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

// ===== rtl/core/aavr_div_cell.sv =====
// One restoring division step for the three axis lanes, one quotient bit each.
module aavr_div_cell
  import aavr_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  div_t d,
  output div_t q
);

  div_t        q_next;
  logic [31:0] r;
  logic        ge;

  always_comb begin
    q_next = d;
    r = '0;
    ge = 1'b0;
    for (int i = 0; i < 3; i++) begin
      r = {d.lane[i].rem, d.lane[i].low[31]};
      ge = r >= {1'b0, d.len};
      q_next.lane[i].rem = ge ? 31'(r - {1'b0, d.len}) : r[30:0];
      q_next.lane[i].low = {d.lane[i].low[30:0], 1'b0};
      q_next.lane[i].q   = {d.lane[i].q[30:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

// ===== rtl/core/axis_angle_vector_rotation_unit.sv =====
// Top level of the pipelined axis-angle vector rotation unit.
//
// Rotates a target vector about an axis of any nonzero length by an angle,
// all in signed fixed point, following Rodrigues' formula.
// Input channel s_*: one item holds target x, y, z, axis x, y, z and the
// angle; output channel m_*: one item holds the rotated x, y, z and two flags.
// The block is a fully pipelined row of stages: while the receiver does not
// stall, a new item may be accepted in every cycle and one result leaves per
// cycle. The depth of the pipeline is set by the 32-cell square root chain
// and the 32-cell divider chain that normalise the axis, plus the multiply
// and rounding stages behind them. The CORDIC runs alongside.
// All stages advance together: when the receiver stalls with a result
// waiting, the whole pipeline holds and s_tready drops; it accepts again as
// soon as the output register is taken or empty.
// Reset clears the valid bits of every stage, so no stale result appears.
// A zero axis passes the target through with zero_axis set; results out of
// range are clamped with saturated set.
module axis_angle_vector_rotation_unit
  import aavr_pkg::*;
#(
  parameter int COORD_WIDTH       = 32,
  parameter int FRAC_BITS         = 16,
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // target_x, target_y, target_z, axis_x, axis_y, axis_z, turn_angle, zero pad
  input  logic [((6*COORD_WIDTH+FRAC_BITS+3+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // result_x, result_y, result_z, zero pad
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
  // zero_axis, saturated
  output logic [1:0] m_tuser
);

  localparam int CW    = COORD_WIDTH;
  localparam int AW    = FRAC_BITS + 3;
  localparam int OUT_W = ((3*CW+7)/8)*8;
  localparam int BW    = $clog2(CW + 1);
  localparam int DW    = CW + 3;
  localparam int CRW   = CW + 2;
  localparam int WW    = CW + 4;
  localparam int RW    = CW + 6;
  localparam int PW    = CW + 40;
  localparam int NST   = 82;
  localparam int CDLY  = 76 - CORDIC_ITERATIONS;

  localparam logic signed [PW-1:0] HALF = PW'(64'sd536870912);
  localparam logic signed [RW-1:0] LIM_HI = RW'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [RW-1:0] LIM_LO = -LIM_HI - RW'(1);
  localparam logic signed [31:0]   U_ONE  = 32'sd1073741824;

  function automatic logic signed [PW-1:0] rnd30(input logic signed [PW-1:0] v);
    return (v + HALF) >>> 30;
  endfunction

  logic       adv;
  logic [NST:1] vld;

  assign adv      = !vld[NST] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[NST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-1:1], s_tvalid};
    end
  end

  // Input fields.
  logic signed [CW-1:0] tin [3];
  logic signed [CW-1:0] ain [3];
  logic signed [AW-1:0] ang_in;
  logic signed [ZW-1:0] ang_q30;

  for (genvar g = 0; g < 3; g++) begin : g_in
    assign tin[g] = $signed(s_tdata[g*CW +: CW]);
    assign ain[g] = $signed(s_tdata[(3+g)*CW +: CW]);
  end
  assign ang_in  = $signed(s_tdata[6*CW +: AW]);
  assign ang_q30 = ZW'(ang_in) <<< (30 - FRAC_BITS);

  // Stage 1: capture, fold the angle into the CORDIC range.
  logic signed [CW-1:0] t1 [3];
  logic signed [CW-1:0] a1 [3];
  cordic_t              cr [CORDIC_ITERATIONS+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        t1[i] <= tin[i];
        a1[i] <= ain[i];
      end
      cr[0].x <= CORDIC_GAIN_Q30;
      cr[0].y <= '0;
      if (ang_q30 > HALF_PI_Q30) begin
        cr[0].z   <= ang_q30 - PI_Q30;
        cr[0].neg <= 1'b1;
      end else if (ang_q30 < -HALF_PI_Q30) begin
        cr[0].z   <= ang_q30 + PI_Q30;
        cr[0].neg <= 1'b1;
      end else begin
        cr[0].z   <= ang_q30;
        cr[0].neg <= 1'b0;
      end
    end
  end

  for (genvar g = 0; g < CORDIC_ITERATIONS; g++) begin : g_cordic
    aavr_cordic_cell #(.I(g)) u_cell (
      .clk (clk),
      .en  (adv),
      .d   (cr[g]),
      .q   (cr[g+1])
    );
  end

  // Undo the fold and line sine and cosine up with the final products.
  logic signed [31:0] cos_f, sin_f;
  logic [63:0]        sc_dly;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (cr[CORDIC_ITERATIONS].neg) begin
        cos_f <= 32'(-cr[CORDIC_ITERATIONS].x);
        sin_f <= 32'(-cr[CORDIC_ITERATIONS].y);
      end else begin
        cos_f <= 32'(cr[CORDIC_ITERATIONS].x);
        sin_f <= 32'(cr[CORDIC_ITERATIONS].y);
      end
    end
  end

  aavr_delay #(.W(64), .DEPTH(CDLY)) u_sc_dly (
    .clk (clk), .en (adv), .d ({sin_f, cos_f}), .q (sc_dly)
  );

  // Stages 2 to 7: axis magnitude, bit length, scaling, sum of squares.
  logic signed [CW-1:0] a2 [3];
  logic signed [CW-1:0] a3 [3];
  logic [CW-1:0]        mag [3];
  logic [CW-1:0]        m2;
  logic [BW-1:0]        b3;
  logic                 zero3;
  logic signed [30:0]   sa4 [3];
  logic [30:0]          sm5 [3];
  logic [2:0]           sg5;
  logic [61:0]          sq6 [3];
  logic [63:0]          sum7;
  logic [BW-1:0]        blen;
  logic signed [63:0]   ae [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = a1[i][CW-1] ? CW'(-a1[i]) : CW'(a1[i]);
    end
    blen = '0;
    for (int k = 0; k < CW; k++) begin
      if (m2[k]) begin
        blen = BW'(k + 1);
      end
    end
    for (int i = 0; i < 3; i++) begin
      ae[i] = 64'(a3[i]);
      if (int'(b3) <= 30) begin
        ae[i] = ae[i] <<< (30 - int'(b3));
      end else begin
        ae[i] = ae[i] >>> (int'(b3) - 30);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a2 <= a1;
      m2 <= (mag[0] > mag[1]) ? ((mag[0] > mag[2]) ? mag[0] : mag[2])
                              : ((mag[1] > mag[2]) ? mag[1] : mag[2]);
      a3    <= a2;
      b3    <= blen;
      zero3 <= (m2 == '0);
      for (int i = 0; i < 3; i++) begin
        sa4[i] <= 31'(ae[i]);
        sm5[i] <= sa4[i][30] ? 31'(-sa4[i]) : 31'(sa4[i]);
        sg5[i] <= sa4[i][30];
        sq6[i] <= sm5[i] * sm5[i];
      end
      sum7 <= 64'(sq6[0]) + 64'(sq6[1]) + 64'(sq6[2]);
    end
  end

  // Square root chain, stages 8 to 39.
  sqrt_t sq_st [33];

  assign sq_st[0].rem = sum7;
  assign sq_st[0].res = '0;

  for (genvar g = 0; g < 32; g++) begin : g_sqrt
    aavr_sqrt_cell #(.K(g)) u_cell (
      .clk (clk),
      .en  (adv),
      .d   (sq_st[g]),
      .q   (sq_st[g+1])
    );
  end

  logic [95:0] sm_dly;

  aavr_delay #(.W(96), .DEPTH(34)) u_sm_dly (
    .clk (clk), .en (adv), .d ({sg5[2], sm5[2], sg5[1], sm5[1], sg5[0], sm5[0]}),
    .q (sm_dly)
  );

  // Stage 40: dividend (magnitude * 2^30 + len/2) split for the divider.
  div_t        dv [33];
  logic [2:0]  sg40;
  logic [60:0] num [3];
  logic [30:0] len39;

  assign len39 = sq_st[32].res[30:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = {sm_dly[i*32 +: 31], 30'b0} + 61'(len39 >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0].len <= len39;
      for (int i = 0; i < 3; i++) begin
        dv[0].lane[i].rem <= {2'b00, num[i][60:32]};
        dv[0].lane[i].low <= num[i][31:0];
        dv[0].lane[i].q   <= '0;
        sg40[i]           <= sm_dly[i*32 + 31];
      end
    end
  end

  for (genvar g = 0; g < 32; g++) begin : g_div
    aavr_div_cell u_cell (
      .clk (clk),
      .en  (adv),
      .d   (dv[g]),
      .q   (dv[g+1])
    );
  end

  logic [2:0] sg72;

  aavr_delay #(.W(3), .DEPTH(32)) u_sg_dly (
    .clk (clk), .en (adv), .d (sg40), .q (sg72)
  );

  // Side data: target and zero-axis flag.
  logic [3*CW-1:0] t_a, t_b, t_c;
  logic            zero73, zero81;

  aavr_delay #(.W(3*CW), .DEPTH(72)) u_ta_dly (
    .clk (clk), .en (adv), .d ({t1[2], t1[1], t1[0]}), .q (t_a)
  );
  aavr_delay #(.W(3*CW), .DEPTH(4)) u_tb_dly (
    .clk (clk), .en (adv), .d (t_a), .q (t_b)
  );
  aavr_delay #(.W(3*CW), .DEPTH(4)) u_tc_dly (
    .clk (clk), .en (adv), .d (t_b), .q (t_c)
  );
  aavr_delay #(.W(1), .DEPTH(70)) u_z1_dly (
    .clk (clk), .en (adv), .d (zero3), .q (zero73)
  );
  aavr_delay #(.W(1), .DEPTH(8)) u_z2_dly (
    .clk (clk), .en (adv), .d (zero73), .q (zero81)
  );

  // Stages 73 to 82: unit axis, products, projection, final sum and clamp.
  logic signed [31:0]  u73 [3];
  logic signed [31:0]  u74 [3];
  logic signed [31:0]  u75 [3];
  logic signed [CW-1:0] ta [3];
  logic signed [CW-1:0] tb [3];
  logic signed [CW-1:0] tc [3];
  logic signed [PW-1:0] pr74 [9];
  logic signed [CRW-1:0] rd [9];
  logic signed [DW-1:0] d75;
  logic signed [CRW-1:0] c75 [3];
  logic [3*CRW-1:0]     c_dly;
  logic signed [PW-1:0] pp76 [3];
  logic signed [DW-1:0] p77 [3];
  logic signed [DW-1:0] p78 [3];
  logic signed [DW-1:0] p79 [3];
  logic signed [DW-1:0] p80 [3];
  logic signed [WW-1:0] w78 [3];
  logic signed [CRW-1:0] c78 [3];
  logic signed [PW-1:0] wc79 [3];
  logic signed [PW-1:0] cz79 [3];
  logic signed [RW-1:0] rw80 [3];
  logic signed [RW-1:0] rc80 [3];
  logic signed [RW-1:0] r81 [3];
  logic signed [31:0]   cs78, sn78;
  logic [OUT_W-1:0]     out_data, out_next;
  logic [1:0]           out_flags, flags_next;

  for (genvar g = 0; g < 3; g++) begin : g_unpack
    assign ta[g]  = $signed(t_a[g*CW +: CW]);
    assign tb[g]  = $signed(t_b[g*CW +: CW]);
    assign tc[g]  = $signed(t_c[g*CW +: CW]);
    assign c78[g] = $signed(c_dly[g*CRW +: CRW]);
  end
  assign cs78 = $signed(sc_dly[31:0]);
  assign sn78 = $signed(sc_dly[63:32]);

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      rd[k] = CRW'(rnd30(pr74[k]));
    end
  end

  aavr_delay #(.W(3*CRW), .DEPTH(3)) u_c_dly (
    .clk (clk), .en (adv), .d ({c75[2], c75[1], c75[0]}), .q (c_dly)
  );

  always_comb begin
    out_next   = '0;
    flags_next = '0;
    for (int i = 0; i < 3; i++) begin
      if (zero81) begin
        out_next[i*CW +: CW] = tc[i];
      end else if (r81[i] > LIM_HI) begin
        out_next[i*CW +: CW] = CW'(LIM_HI);
        flags_next[1] = 1'b1;
      end else if (r81[i] < LIM_LO) begin
        out_next[i*CW +: CW] = CW'(LIM_LO);
        flags_next[1] = 1'b1;
      end else begin
        out_next[i*CW +: CW] = CW'(r81[i]);
      end
    end
    flags_next[0] = zero81;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        u73[i] <= sg72[i] ? -$signed(dv[32].lane[i].q) : $signed(dv[32].lane[i].q);
      end
      u74 <= u73;
      pr74[0] <= ta[0] * u73[0];
      pr74[1] <= ta[1] * u73[1];
      pr74[2] <= ta[2] * u73[2];
      pr74[3] <= ta[2] * u73[1];
      pr74[4] <= ta[1] * u73[2];
      pr74[5] <= ta[0] * u73[2];
      pr74[6] <= ta[2] * u73[0];
      pr74[7] <= ta[1] * u73[0];
      pr74[8] <= ta[0] * u73[1];
      u75 <= u74;
      d75 <= DW'(rd[0]) + DW'(rd[1]) + DW'(rd[2]);
      c75[0] <= rd[3] - rd[4];
      c75[1] <= rd[5] - rd[6];
      c75[2] <= rd[7] - rd[8];
      for (int i = 0; i < 3; i++) begin
        pp76[i] <= d75 * u75[i];
        p77[i]  <= DW'(rnd30(pp76[i]));
        w78[i]  <= WW'(tb[i]) - WW'(p77[i]);
        p78[i]  <= p77[i];
        wc79[i] <= w78[i] * cs78;
        cz79[i] <= c78[i] * sn78;
        p79[i]  <= p78[i];
        rw80[i] <= RW'(rnd30(wc79[i]));
        rc80[i] <= RW'(rnd30(cz79[i]));
        p80[i]  <= p79[i];
        r81[i]  <= RW'(p80[i]) + rw80[i] + rc80[i];
      end
      out_data  <= out_next;
      out_flags <= flags_next;
    end
  end

  assign m_tdata = out_data;
  assign m_tuser = out_flags;

  // A passed-through target is never reported as clamped.
  a_zero_not_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> !m_tuser[1])
    else $error("zero axis result flagged as saturated");

  // A clamped result has at least one component on a range bound.
  a_sat_on_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |->
      (m_tdata[CW-1:0] == CW'(LIM_HI)) || (m_tdata[CW-1:0] == CW'(LIM_LO)) ||
      (m_tdata[2*CW-1:CW] == CW'(LIM_HI)) || (m_tdata[2*CW-1:CW] == CW'(LIM_LO)) ||
      (m_tdata[3*CW-1:2*CW] == CW'(LIM_HI)) || (m_tdata[3*CW-1:2*CW] == CW'(LIM_LO)))
    else $error("saturated flag without a clamped component");

  // The normalised axis never exceeds unit length in any component.
  a_unit_bound: assert property (@(posedge clk) disable iff (rst)
    vld[73] && !zero73 |->
      (u73[0] <= U_ONE) && (u73[0] >= -U_ONE) &&
      (u73[1] <= U_ONE) && (u73[1] >= -U_ONE) &&
      (u73[2] <= U_ONE) && (u73[2] >= -U_ONE))
    else $error("unit axis component out of range");

endmodule
